// ===== hw/rtl/btd_pkg.sv =====
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types and constants of the byte-level token text decoder.
// ----------------------------------------------------------------------------
package btd_pkg;

	// capacity register
	localparam int unsigned CAP_W     = 13;
	localparam logic [CAP_W-1:0] CAP_RESET = 13'd64;
	localparam logic [CAP_W-1:0] CAP_MAX   = 13'd4096;

	// decoded byte count within one string
	localparam int unsigned WC_W = 12;

	// default depth of the result group queue
	localparam int unsigned Q_DEPTH = 4;

	// most results one input byte can cause
	localparam int unsigned GRP_MAX = 3;

	// utf-8 class masks and patterns
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_PAT   = 8'h80;

	// remapped code point window and control byte limit
	localparam logic [10:0] CP_LO   = 11'h100;
	localparam logic [10:0] CP_HI   = 11'h143;
	localparam logic [7:0]  CTRL_LIM = 8'h20;
	localparam logic [7:0]  CH_TAB  = 8'h09;
	localparam logic [7:0]  CH_LF   = 8'h0A;
	localparam logic [7:0]  CH_CR   = 8'h0D;

	// results caused by one input byte, in order
	typedef struct packed {
		logic [1:0]                 cnt;
		logic [GRP_MAX-1:0][7:0]    bytes;
		logic [GRP_MAX-1:0]         lasts;
	} grp_t;

endpackage

// ===== hw/rtl/btd_if.sv =====
// ----------------------------------------------------------------------------
// btd_in_if / btd_out_if
// Valid/ready channels of the byte-level token text decoder.
// ----------------------------------------------------------------------------
interface btd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface btd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/btd_front.sv =====
// ----------------------------------------------------------------------------
// btd_front
// Classifies each input byte, tracks held sequence bytes and the output
// budget, and pushes the group of results it causes into the queue.
// ----------------------------------------------------------------------------
module btd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [btd_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	input  logic [7:0]                in_byte,
	output logic                      in_ready,
	input  logic                      q_full,
	output logic                      push,
	output btd_pkg::grp_t             push_grp
);
	import btd_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] cap_eff;
	logic [WC_W-1:0]  wc_q, wc_d;
	logic [1:0]       held_cnt_q, held_cnt_d;
	logic [7:0]       held0_q, held0_d, held1_q, held1_d;
	logic             acc;
	logic [CAP_W:0]   wc_ext;
	logic             f1, f2, f3;
	logic             b_zero, b_lead2, b_lead3, b_cont, c0_lead2;
	logic [10:0]      cp;
	logic [7:0]       raw;
	logic             keep;
	logic [1:0]       n;
	grp_t             grp;

	assign in_ready = !q_full;
	assign acc      = in_valid && !q_full;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// clamp capacity to 1..4096
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cap_q > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cap_q;
		end
	end

	// budget checks
	assign wc_ext = (CAP_W + 1)'(wc_q);
	assign f1     = (wc_ext + (CAP_W + 1)'(1)) < (CAP_W + 1)'(cap_eff);
	assign f2     = (wc_ext + (CAP_W + 1)'(2)) < (CAP_W + 1)'(cap_eff);
	assign f3     = (wc_ext + (CAP_W + 1)'(3)) < (CAP_W + 1)'(cap_eff);

	// byte classes
	assign b_zero   = (in_byte == 8'h00);
	assign b_lead2  = (in_byte & LEAD2_MASK) == LEAD2_PAT;
	assign b_lead3  = (in_byte & LEAD3_MASK) == LEAD3_PAT;
	assign b_cont   = (in_byte & CONT_MASK) == CONT_PAT;
	assign c0_lead2 = (held0_q & LEAD2_MASK) == LEAD2_PAT;

	// two-byte code point and its remapped raw byte
	assign cp   = {held0_q[4:0], in_byte[5:0]};
	assign raw  = cp[7:0];
	assign keep = (raw >= CTRL_LIM) || (raw == CH_LF) || (raw == CH_CR) || (raw == CH_TAB);

	// results and next state for the current byte
	always_comb begin
		grp        = '0;
		n          = 2'd0;
		held_cnt_d = held_cnt_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		wc_d       = wc_q;
		if (b_zero) begin
			// flush held bytes singly, then the terminator
			if (held_cnt_q != 2'd0 && f1) begin
				grp.bytes[n] = held0_q;
				n = n + 2'd1;
			end
			if (held_cnt_q == 2'd2 && f2) begin
				grp.bytes[n] = held1_q;
				n = n + 2'd1;
			end
			grp.bytes[n] = 8'h00;
			grp.lasts[n] = 1'b1;
			n = n + 2'd1;
			held_cnt_d = 2'd0;
			wc_d       = '0;
		end else begin
			case (held_cnt_q)
				2'd0: begin
					if (f1) begin
						if (b_lead2 || b_lead3) begin
							held0_d    = in_byte;
							held_cnt_d = 2'd1;
						end else begin
							grp.bytes[n] = in_byte;
							n = n + 2'd1;
						end
					end
				end
				2'd1: begin
					if (c0_lead2) begin
						held_cnt_d = 2'd0;
						if (b_cont) begin
							if (cp >= CP_LO && cp <= CP_HI) begin
								if (keep && f1) begin
									grp.bytes[n] = raw;
									n = n + 2'd1;
								end
							end else if (f2) begin
								grp.bytes[n] = held0_q;
								n = n + 2'd1;
								grp.bytes[n] = in_byte;
								n = n + 2'd1;
							end
						end else begin
							// broken sequence: lead goes out singly, byte starts afresh
							if (f1) begin
								grp.bytes[n] = held0_q;
								n = n + 2'd1;
							end
							if (f2) begin
								if (b_lead2 || b_lead3) begin
									held0_d    = in_byte;
									held_cnt_d = 2'd1;
								end else begin
									grp.bytes[n] = in_byte;
									n = n + 2'd1;
								end
							end
						end
					end else begin
						held1_d    = in_byte;
						held_cnt_d = 2'd2;
					end
				end
				default: begin
					held_cnt_d = 2'd0;
					if (f3) begin
						grp.bytes[n] = held0_q;
						n = n + 2'd1;
						grp.bytes[n] = held1_q;
						n = n + 2'd1;
						grp.bytes[n] = in_byte;
						n = n + 2'd1;
					end
				end
			endcase
			wc_d = wc_q + WC_W'(n);
		end
		grp.cnt = n;
	end

	assign push     = acc && (n != 2'd0);
	assign push_grp = grp;

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			wc_q       <= '0;
		end else if (acc) begin
			held_cnt_q <= held_cnt_d;
			held0_q    <= held0_d;
			held1_q    <= held1_d;
			wc_q       <= wc_d;
		end
	end

endmodule

// ===== hw/rtl/btd_queue.sv =====
// ----------------------------------------------------------------------------
// btd_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module btd_queue #(
	parameter int unsigned DEPTH = btd_pkg::Q_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  btd_pkg::grp_t push_grp,
	input  logic          pop,
	output btd_pkg::grp_t head,
	output logic          empty,
	output logic          full
);
	import btd_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	grp_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/btd_back.sv =====
// ----------------------------------------------------------------------------
// btd_back
// Walks the head group of the queue and sends one result byte per cycle,
// while the output is ready, through the output register.
// ----------------------------------------------------------------------------
module btd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  btd_pkg::grp_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import btd_pkg::*;

	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;
	logic [1:0] idx_q;
	logic       load;
	logic       at_end;

	assign load   = !q_empty && (!ov_q || out_ready);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && at_end;

	// position within the head group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			ov_q  <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
				ov_q  <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= head.bytes[idx_q];
			ol_q <= head.lasts[idx_q];
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign out_last  = ol_q;

endmodule

// ===== hw/rtl/byte_level_token_text_decoder.sv =====
// ----------------------------------------------------------------------------
// byte_level_token_text_decoder
// Maps the byte-level UTF-8 form of token strings back to plain bytes.
// ----------------------------------------------------------------------------
// in_ch carries one token string byte per transfer; byte 0 ends the string.
// out_ch carries decoded bytes; the closing 0 byte of each string has last=1.
// cfg_we/cfg_wdata write the output capacity (reset 64); write while idle.
// One input transfer is taken per cycle while the group queue has room;
// each byte yields zero to three results, queued as one group if any.
// The back stage sends one result per cycle while out_ch is ready; each result
// is registered in the queue and then in the output register.
// The sustained rate is one input byte per cycle, bounded on average by the
// single output port; the queue of QUEUE_DEPTH groups absorbs bursts.
// When out_ch stalls, results stay in the output register and the queue,
// and in_ch.ready drops only once the queue is full.
// Reset clears held sequence bytes, the byte count and the queue, and sets
// the capacity back to 64.
// ----------------------------------------------------------------------------
module byte_level_token_text_decoder #(
	parameter int unsigned QUEUE_DEPTH = btd_pkg::Q_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [btd_pkg::CAP_W-1:0] cfg_wdata,
	btd_in_if.sink                    in_ch,
	btd_out_if.source                 out_ch
);
	import btd_pkg::*;

	logic push, pop, q_empty, q_full;
	grp_t push_grp, head;

	// classify and budget
	btd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_ch.valid),
		.in_byte   (in_ch.in_byte),
		.in_ready  (in_ch.ready),
		.q_full    (q_full),
		.push      (push),
		.push_grp  (push_grp)
	);

	// result group queue
	btd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// serialize onto the output channel
	btd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_byte  (out_ch.out_byte),
		.out_last  (out_ch.last)
	);

endmodule
